// ----- src/tsqm_pkg.sv -----
// shared types and constants for the task slot queue manager
// no dependencies; compiled first
package tsqm_pkg;

  localparam int unsigned POOL_SLOTS = 64;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned LINK_W     = SLOT_W + 1;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ID_W       = 32;

  // null link sits just past the last slot; its top bit marks it
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_SLOTS);
  localparam logic [ID_W-1:0]   ID_START = ID_W'(1000);
  localparam logic [CNT_W-1:0]  FREE_RESET = CNT_W'(POOL_SLOTS);

  typedef enum logic [2:0] {
    KIND_ALLOC = 3'd0,
    KIND_ENQ   = 3'd1,
    KIND_DEQ   = 3'd2,
    KIND_RET   = 3'd3,
    KIND_FETCH = 3'd4,
    KIND_FREE  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_FREE    = 2'd1,
    STATUS_TASK_EMPTY = 2'd2,
    STATUS_RES_EMPTY  = 2'd3
  } status_e;

  // one access on the link memory port
  typedef struct packed {
    logic              en;
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } link_req_t;

endpackage

// ----- src/tsqm_if.sv -----
// command and result channel interfaces for the task slot queue manager
// depends on tsqm_pkg
interface tsqm_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  kind;
  logic [tsqm_pkg::SLOT_W-1:0] slot;

  modport source (output valid, kind, slot, input ready);
  modport sink (input valid, kind, slot, output ready);
endinterface

interface tsqm_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [tsqm_pkg::SLOT_W-1:0] slot_out;
  logic [tsqm_pkg::ID_W-1:0]   msg_id;
  logic [tsqm_pkg::CNT_W-1:0]  free_count;
  logic [tsqm_pkg::CNT_W-1:0]  task_count;
  logic [tsqm_pkg::CNT_W-1:0]  result_count;
  logic [tsqm_pkg::CNT_W-1:0]  outstanding_count;

  modport source (
    output valid, status, slot_out, msg_id, free_count, task_count, result_count,
           outstanding_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot_out, msg_id, free_count, task_count, result_count,
           outstanding_count,
    output ready
  );
endinterface

// ----- src/task_slot_queue_manager_unit.sv -----
// task slot queue manager: free list, task fifo and result fifo over one slot pool
// depends on tsqm_pkg, tsqm_if (tsqm_cmd_if, tsqm_res_if) and tsqm_link_mem
//
//   channel  dir  fields                                      transaction
//   cmd_i    in   kind, slot                                  valid & ready
//   res_o    out  status, slot_out, msg_id, four counters     valid & ready
//
// each command runs three steps: accept, issue on the link memory port, finish
// the single link memory port is the shared unit; enqueue and return need up to two writes,
//   pops need a read then a write, so every command runs the same three steps
// finish waits while an earlier result still sits unconsumed in the output register
// a new command is accepted as soon as the sequencer is idle, even with a result pending
// reset is asynchronous and takes effect at once; no clearing pass is needed
module task_slot_queue_manager_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  tsqm_cmd_if.sink     cmd_i,
  tsqm_res_if.source   res_o
);
  import tsqm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_e;

  // sequencer and command registers
  state_e            state_q, state_d;
  logic [2:0]        kind_q, kind_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  // list pointers and counters
  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [LINK_W-1:0] task_head_q, task_head_d;
  logic [LINK_W-1:0] task_tail_q, task_tail_d;
  logic [LINK_W-1:0] res_head_q, res_head_d;
  logic [LINK_W-1:0] res_tail_q, res_tail_d;
  logic [CNT_W-1:0]  free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]  task_cnt_q, task_cnt_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic [CNT_W-1:0]  outst_cnt_q, outst_cnt_d;
  logic [ID_W-1:0]   id_cnt_q, id_cnt_d;

  // result register
  logic              res_valid_q, res_valid_d;
  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [CNT_W-1:0]  res_free_q, res_free_d;
  logic [CNT_W-1:0]  res_task_q, res_task_d;
  logic [CNT_W-1:0]  res_rcnt_q, res_rcnt_d;
  logic [CNT_W-1:0]  res_outst_q, res_outst_d;

  // id memory, undefined until written
  logic [ID_W-1:0]   id_mem [POOL_SLOTS];
  logic [ID_W-1:0]   id_rd_q;
  logic [SLOT_W-1:0] id_raddr;

  // link memory port
  link_req_t         link_req;
  logic [LINK_W-1:0] link_rdata;

  // command decode
  logic              is_alloc, is_enq, is_deq, is_ret, is_fetch, is_free;
  logic              cmd_ok, is_pop, fin_go;
  logic [LINK_W-1:0] head_sel;
  status_e           status_sel;

  always_comb begin
    is_alloc = (kind_q == KIND_ALLOC);
    is_enq   = (kind_q == KIND_ENQ);
    is_deq   = (kind_q == KIND_DEQ);
    is_ret   = (kind_q == KIND_RET);
    is_fetch = (kind_q == KIND_FETCH);
    is_free  = (kind_q == KIND_FREE);
    is_pop   = is_alloc || is_deq || is_fetch;

    // head of the list a pop works on
    priority if (is_alloc) begin
      head_sel = free_head_q;
    end else if (is_deq) begin
      head_sel = task_head_q;
    end else if (is_fetch) begin
      head_sel = res_head_q;
    end else begin
      head_sel = {1'b0, slot_q};
    end

    // a pop on a null head is an error and leaves everything untouched
    cmd_ok = !(is_pop && head_sel[LINK_W-1]);

    priority if (cmd_ok) begin
      status_sel = STATUS_OK;
    end else if (is_alloc) begin
      status_sel = STATUS_NO_FREE;
    end else if (is_deq) begin
      status_sel = STATUS_TASK_EMPTY;
    end else begin
      status_sel = STATUS_RES_EMPTY;
    end
  end

  // finish only once the output register can take the result
  assign fin_go   = (state_q == ST_FINISH) && (!res_valid_q || res_o.ready);
  assign id_raddr = (cmd_ok && (is_deq || is_fetch)) ? head_sel[SLOT_W-1:0] : slot_q;

  // link memory schedule: issue does the read or first write, finish the second write
  always_comb begin
    link_req = '0;
    if (state_q == ST_ISSUE) begin
      if (is_pop && cmd_ok) begin
        link_req.en   = 1'b1;
        link_req.addr = head_sel[SLOT_W-1:0];
      end else if (is_enq || is_ret) begin
        link_req.en    = 1'b1;
        link_req.we    = 1'b1;
        link_req.addr  = slot_q;
        link_req.wdata = NIL_LINK;
      end else if (is_free) begin
        link_req.en    = 1'b1;
        link_req.we    = 1'b1;
        link_req.addr  = slot_q;
        link_req.wdata = free_head_q;
      end
    end else if (fin_go) begin
      if (is_pop && cmd_ok) begin
        // unlink the popped slot
        link_req.en    = 1'b1;
        link_req.we    = 1'b1;
        link_req.addr  = head_sel[SLOT_W-1:0];
        link_req.wdata = NIL_LINK;
      end else if (is_enq && !task_head_q[LINK_W-1] && !task_tail_q[LINK_W-1]) begin
        link_req.en    = 1'b1;
        link_req.we    = 1'b1;
        link_req.addr  = task_tail_q[SLOT_W-1:0];
        link_req.wdata = {1'b0, slot_q};
      end else if (is_ret && !res_head_q[LINK_W-1] && !res_tail_q[LINK_W-1]) begin
        link_req.en    = 1'b1;
        link_req.we    = 1'b1;
        link_req.addr  = res_tail_q[SLOT_W-1:0];
        link_req.wdata = {1'b0, slot_q};
      end
    end
  end

  tsqm_link_mem u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  // id memory: read during issue, stamped on allocate at finish
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ISSUE) begin
      id_rd_q <= id_mem[id_raddr];
    end
    if (fin_go && is_alloc && cmd_ok) begin
      id_mem[free_head_q[SLOT_W-1:0]] <= id_cnt_q;
    end
  end

  // next state of sequencer, lists, counters and result register
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    slot_d      = slot_q;
    free_head_d = free_head_q;
    task_head_d = task_head_q;
    task_tail_d = task_tail_q;
    res_head_d  = res_head_q;
    res_tail_d  = res_tail_q;
    free_cnt_d  = free_cnt_q;
    task_cnt_d  = task_cnt_q;
    res_cnt_d   = res_cnt_q;
    outst_cnt_d = outst_cnt_q;
    id_cnt_d    = id_cnt_q;

    res_valid_d  = res_valid_q && !res_o.ready;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_id_d     = res_id_q;
    res_free_d   = res_free_q;
    res_task_d   = res_task_q;
    res_rcnt_d   = res_rcnt_q;
    res_outst_d  = res_outst_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          kind_d  = cmd_i.kind;
          slot_d  = cmd_i.slot;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_d = ST_IDLE;
          if (cmd_ok) begin
            unique case (kind_q)
              KIND_ALLOC: begin
                free_head_d = link_rdata;
                free_cnt_d  = free_cnt_q - CNT_W'(1);
                id_cnt_d    = id_cnt_q + ID_W'(1);
              end
              KIND_ENQ: begin
                if (task_head_q[LINK_W-1] || task_tail_q[LINK_W-1]) begin
                  task_head_d = {1'b0, slot_q};
                end
                task_tail_d = {1'b0, slot_q};
                task_cnt_d  = task_cnt_q + CNT_W'(1);
                outst_cnt_d = outst_cnt_q + CNT_W'(1);
              end
              KIND_DEQ: begin
                task_head_d = link_rdata;
                if (link_rdata[LINK_W-1]) begin
                  task_tail_d = NIL_LINK;
                end
                task_cnt_d = task_cnt_q - CNT_W'(1);
              end
              KIND_RET: begin
                if (res_head_q[LINK_W-1] || res_tail_q[LINK_W-1]) begin
                  res_head_d = {1'b0, slot_q};
                end
                res_tail_d = {1'b0, slot_q};
                res_cnt_d  = res_cnt_q + CNT_W'(1);
              end
              KIND_FETCH: begin
                res_head_d = link_rdata;
                if (link_rdata[LINK_W-1]) begin
                  res_tail_d = NIL_LINK;
                end
                res_cnt_d   = res_cnt_q - CNT_W'(1);
                outst_cnt_d = outst_cnt_q - CNT_W'(1);
              end
              KIND_FREE: begin
                free_head_d = {1'b0, slot_q};
                free_cnt_d  = free_cnt_q + CNT_W'(1);
              end
              default: begin
                // unused kinds change nothing
              end
            endcase
          end

          // load the result register with the counters after the update
          res_valid_d  = 1'b1;
          res_status_d = status_sel;
          res_slot_d   = (is_pop && cmd_ok) ? head_sel[SLOT_W-1:0] : slot_q;
          res_id_d     = (is_alloc && cmd_ok) ? id_cnt_q : id_rd_q;
          res_free_d   = free_cnt_d;
          res_task_d   = task_cnt_d;
          res_rcnt_d   = res_cnt_d;
          res_outst_d  = outst_cnt_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= '0;
      slot_q       <= '0;
      free_head_q  <= '0;
      task_head_q  <= NIL_LINK;
      task_tail_q  <= NIL_LINK;
      res_head_q   <= NIL_LINK;
      res_tail_q   <= NIL_LINK;
      free_cnt_q   <= FREE_RESET;
      task_cnt_q   <= '0;
      res_cnt_q    <= '0;
      outst_cnt_q  <= '0;
      id_cnt_q     <= ID_START;
      res_valid_q  <= 1'b0;
      res_status_q <= STATUS_OK;
      res_slot_q   <= '0;
      res_id_q     <= '0;
      res_free_q   <= '0;
      res_task_q   <= '0;
      res_rcnt_q   <= '0;
      res_outst_q  <= '0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      slot_q       <= slot_d;
      free_head_q  <= free_head_d;
      task_head_q  <= task_head_d;
      task_tail_q  <= task_tail_d;
      res_head_q   <= res_head_d;
      res_tail_q   <= res_tail_d;
      free_cnt_q   <= free_cnt_d;
      task_cnt_q   <= task_cnt_d;
      res_cnt_q    <= res_cnt_d;
      outst_cnt_q  <= outst_cnt_d;
      id_cnt_q     <= id_cnt_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_id_q     <= res_id_d;
      res_free_q   <= res_free_d;
      res_task_q   <= res_task_d;
      res_rcnt_q   <= res_rcnt_d;
      res_outst_q  <= res_outst_d;
    end
  end

  // ports
  assign cmd_i.ready             = (state_q == ST_IDLE);
  assign res_o.valid             = res_valid_q;
  assign res_o.status            = res_status_q;
  assign res_o.slot_out          = res_slot_q;
  assign res_o.msg_id            = res_id_q;
  assign res_o.free_count        = res_free_q;
  assign res_o.task_count        = res_task_q;
  assign res_o.result_count      = res_rcnt_q;
  assign res_o.outstanding_count = res_outst_q;

`ifndef NO_ASSERTIONS
  // an accepted command always moves straight to the memory issue step
  a_accept_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (state_q == ST_ISSUE))
    else $error("accepted command did not enter issue");

  // a result appears only from the finish step
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish");

  // the running id moves only on a successful allocate
  a_id_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(id_cnt_q) |-> $past(fin_go && is_alloc && cmd_ok))
    else $error("id counter changed without an allocate");

  // an error status leaves lists and counters untouched
  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && !cmd_ok) |=> ($stable(free_head_q) && $stable(task_head_q) &&
      $stable(res_head_q) && $stable(free_cnt_q) && $stable(task_cnt_q) &&
      $stable(res_cnt_q) && $stable(outst_cnt_q)))
    else $error("failed command changed state");

  // no link memory access while idle
  a_mem_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !link_req.en)
    else $error("link memory accessed while idle");
`endif

endmodule

// ----- src/tsqm_link_mem.sv -----
// single-port link memory with registered read data
// per-entry valid bits: an entry never written reads as its reset link (index + 1)
// depends on tsqm_pkg
module tsqm_link_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsqm_pkg::link_req_t         req_i,
  output logic [tsqm_pkg::LINK_W-1:0] rdata_o
);
  import tsqm_pkg::*;

  logic [LINK_W-1:0]     mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] vld_q;
  logic [LINK_W-1:0]     rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.en && req_i.we) begin
      vld_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else if (vld_q[req_i.addr]) begin
        rdata_q <= mem[req_i.addr];
      end else begin
        rdata_q <= LINK_W'({1'b0, req_i.addr}) + LINK_W'(1);
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
